// ----- rtl/arpnc_pkg.sv -----
package arpnc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = 5;

    // request kinds
    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_LOOKUP  = 2'd1;
    localparam logic [1:0] REQ_RESOLVE = 2'd2;
    localparam logic [1:0] REQ_ARP_RX  = 2'd3;

    // entry states
    localparam logic [1:0] ENT_FREE       = 2'd0;
    localparam logic [1:0] ENT_INCOMPLETE = 2'd1;
    localparam logic [1:0] ENT_RESOLVED   = 2'd2;

    // result status codes
    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_MISS    = 2'd1;
    localparam logic [1:0] RES_PENDING = 2'd2;
    localparam logic [1:0] RES_IGNORED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_IP   = 2'd0;
    localparam logic [1:0] CFG_MASK     = 2'd1;
    localparam logic [1:0] CFG_OWN_MAC  = 2'd2;
    localparam logic [1:0] CFG_LOOPBACK = 2'd3;

    // header field values of an Ethernet/IPv4 ARP packet
    localparam logic [15:0] ARP_HTYPE_ETH = 16'h0001;
    localparam logic [15:0] ARP_PTYPE_IP4 = 16'h0800;
    localparam logic [7:0]  ARP_HLEN      = 8'd6;
    localparam logic [7:0]  ARP_PLEN      = 8'd4;
    localparam logic [15:0] ARP_OP_REQ    = 16'h0001;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } arpnc_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] peer_ip;
        logic [47:0] peer_mac;
        logic [31:0] target_ip;
        logic [15:0] arp_opcode;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic        frame_long_enough;
    } arpnc_in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [47:0]      result_mac;
        logic             send_request;
        logic             send_reply;
        logic [31:0]      out_peer_ip;
        logic [47:0]      out_peer_mac;
        logic [CNT_W-1:0] entries_in_use;
    } arpnc_out_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic             active;
        logic [31:0]      key;
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic [1:0]       found_status;
        logic [47:0]      found_mac;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [IDX_W-1:0] old_idx;
        logic [31:0]      old_age;
        logic [CNT_W-1:0] used;
    } arpnc_token_t;

    // update broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [1:0]       status;
        logic             set_ip;
        logic [31:0]      ip;
        logic             set_mac;
        logic [47:0]      mac;
        logic [31:0]      age;
    } arpnc_wr_t;

endpackage

// ----- rtl/arpnc_cell.sv -----
module arpnc_cell
    import arpnc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  arpnc_token_t     tok_in,
    output arpnc_token_t     tok_out,
    input  arpnc_wr_t        wr
);

    logic [1:0]   status_reg;
    logic [31:0]  ip_reg;
    logic [47:0]  mac_reg;
    logic [31:0]  age_reg;
    arpnc_token_t tok_reg;
    arpnc_token_t tok_next;

    // fold this entry into the passing token
    always_comb begin
        tok_next = tok_in;
        if (tok_in.active && status_reg != ENT_FREE) begin
            tok_next.used = tok_in.used + CNT_W'(1);
            if (!tok_in.found && ip_reg == tok_in.key) begin
                tok_next.found        = 1'b1;
                tok_next.found_idx    = cell_idx;
                tok_next.found_status = status_reg;
                tok_next.found_mac    = mac_reg;
            end
            if (age_reg < tok_in.old_age) begin
                tok_next.old_idx = cell_idx;
                tok_next.old_age = age_reg;
            end
        end
        if (tok_in.active && status_reg == ENT_FREE && !tok_in.free_found) begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= ENT_FREE;
        end else if (wr.en && wr.idx == cell_idx) begin
            status_reg <= wr.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && wr.idx == cell_idx) begin
            age_reg <= wr.age;
            if (wr.set_ip) begin
                ip_reg <= wr.ip;
            end
            if (wr.set_mac) begin
                mac_reg <= wr.mac;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/arp_neighbor_cache_core.sv -----
// IPv4-to-MAC neighbor table held in a row of CACHE_ENTRIES cells. For each
// beat on s_, a search token walks the cell chain one cell per cycle (match,
// first free slot, oldest slot, usage count); then the update is applied and
// the result registered once m_ is free. One request is handled at a time;
// s_ready is high only while no request is in work. The result register lets
// the next request start while a result waits on m_. The user must write
// configuration (cfg_we/cfg_addr/cfg_wdata) only while idle; unenforced.
module arp_neighbor_cache_core
    import arpnc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  arpnc_in_t   s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output arpnc_out_t  m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [47:0] cfg_wdata
);

    arpnc_state_t state_reg, state_next;
    arpnc_in_t    req_reg;
    arpnc_token_t res_reg;
    logic [31:0]  clock_reg, clock_next;
    logic         m_valid_reg;
    arpnc_out_t   m_data_reg, m_data_next;
    logic         load_out;

    logic [31:0]  own_ip_reg;
    logic [31:0]  mask_reg;
    logic [47:0]  own_mac_reg;
    logic         loop_reg;

    arpnc_token_t chain [CACHE_ENTRIES+1];
    arpnc_token_t tok_first;
    arpnc_wr_t    wr;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg  <= '0;
            mask_reg    <= '0;
            own_mac_reg <= '0;
            loop_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_OWN_IP:   own_ip_reg  <= cfg_wdata[31:0];
                CFG_MASK:     mask_reg    <= cfg_wdata[31:0];
                CFG_OWN_MAC:  own_mac_reg <= cfg_wdata;
                CFG_LOOPBACK: loop_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // token injected at the head of the chain on an accepted beat
    always_comb begin
        tok_first            = '0;
        tok_first.active     = s_valid && s_ready;
        tok_first.key        = s_data.peer_ip;
        tok_first.old_age    = '1;
    end

    assign chain[0] = tok_first;

    for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
        arpnc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(i)),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1]),
            .wr       (wr)
        );
    end

    // control sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_SCAN;
            ST_SCAN: if (chain[CACHE_ENTRIES].active) state_next = ST_DONE;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (chain[CACHE_ENTRIES].active) begin
            res_reg <= chain[CACHE_ENTRIES];
        end
    end

    // decide update and result from the finished search
    always_comb begin
        logic [IDX_W-1:0] slot;
        logic             directed;
        logic             hdr_ok;
        logic             learn;
        slot = res_reg.found ? res_reg.found_idx :
               (res_reg.free_found ? res_reg.free_idx : res_reg.old_idx);
        directed = (mask_reg != '0) &&
                   ((req_reg.peer_ip & mask_reg) == (own_ip_reg & mask_reg)) &&
                   ((req_reg.peer_ip & ~mask_reg) == ~mask_reg);
        hdr_ok = req_reg.frame_long_enough && req_reg.hw_type == ARP_HTYPE_ETH &&
                 req_reg.proto_type == ARP_PTYPE_IP4 && req_reg.hw_len == ARP_HLEN &&
                 req_reg.proto_len == ARP_PLEN;
        learn = 1'b0;
        m_data_next = '0;
        wr          = '0;
        wr.idx      = slot;
        wr.ip       = req_reg.peer_ip;
        wr.mac      = req_reg.peer_mac;
        wr.age      = clock_reg + 32'd1;
        wr.set_ip   = !res_reg.found;

        unique case (req_reg.req_type)
            REQ_INSERT: begin
                if (req_reg.peer_ip == '0) m_data_next.status = RES_IGNORED;
                else learn = 1'b1;
            end
            REQ_LOOKUP: begin
                if (res_reg.found && res_reg.found_status == ENT_RESOLVED) begin
                    m_data_next.result_mac = res_reg.found_mac;
                end else begin
                    m_data_next.status = RES_MISS;
                end
            end
            REQ_RESOLVE: begin
                if (loop_reg) begin
                    m_data_next.result_mac = own_mac_reg;
                end else if (req_reg.peer_ip == '1 || directed) begin
                    m_data_next.result_mac = '1;
                end else if (res_reg.found && res_reg.found_status == ENT_RESOLVED) begin
                    m_data_next.result_mac = res_reg.found_mac;
                end else begin
                    wr.en                    = 1'b1;
                    wr.status                = ENT_INCOMPLETE;
                    m_data_next.status       = RES_PENDING;
                    m_data_next.send_request = 1'b1;
                    m_data_next.out_peer_ip  = req_reg.peer_ip;
                end
            end
            REQ_ARP_RX: begin
                if (!hdr_ok) begin
                    m_data_next.status = RES_IGNORED;
                end else begin
                    learn = (req_reg.peer_ip != '0);
                    if (req_reg.arp_opcode == ARP_OP_REQ && own_ip_reg != '0 &&
                        req_reg.target_ip == own_ip_reg) begin
                        m_data_next.send_reply   = 1'b1;
                        m_data_next.out_peer_ip  = req_reg.peer_ip;
                        m_data_next.out_peer_mac = req_reg.peer_mac;
                    end
                end
            end
            default: ;
        endcase

        if (learn) begin
            wr.en      = 1'b1;
            wr.status  = ENT_RESOLVED;
            wr.set_mac = 1'b1;
        end
        m_data_next.entries_in_use = res_reg.used +
            CNT_W'(wr.en && !res_reg.found && res_reg.free_found);
        wr.en      = wr.en && load_out;
        clock_next = wr.en ? wr.age : clock_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg <= '0;
        end else begin
            clock_reg <= clock_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_exit_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[CACHE_ENTRIES].active |-> state_reg == ST_SCAN)
        else $error("search token left the chain outside a scan");
    a_write_in_done: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> state_reg == ST_DONE)
        else $error("table update outside the finish cycle");
    a_clock_step: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |=> clock_reg == $past(clock_reg) + 32'd1)
        else $error("update clock did not advance on an update");
    a_single_token: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> !tok_first.active)
        else $error("second token injected during a scan");
`endif

endmodule
